FILE: hdl/text_readability_grade_top_macros.svh
// assertion macros for the readability grade block
// used by trg_grade_unit and text_readability_grade_top, no other dependencies
`ifndef TEXT_READABILITY_GRADE_TOP_MACROS_SVH
`define TEXT_READABILITY_GRADE_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define TRG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");
// next-cycle implication
`define TRG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`else
`define TRG_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TRG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/trg_pkg.sv
// shared types and constants for the readability grade block
// no dependencies
`default_nettype none
package trg_pkg;

    localparam int KW = 12;
    localparam logic [KW-1:0] K_LET = 12'd588;
    localparam logic [KW-1:0] K_SEN = 12'd2960;
    localparam logic [KW-1:0] K_WRD = 12'd1580;
    localparam logic [KW-1:0] K_DEN = 12'd100;
    localparam logic [4:0] BAND_MAX = 5'd16;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } trg_in_t;

    typedef struct packed {
        logic [4:0]  grade_band;
        logic [15:0] letter_total;
        logic [16:0] word_total;
        logic [15:0] sentence_total;
    } trg_out_t;

    typedef struct packed {
        logic start;
        logic out_free;
    } trg_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } trg_sts_t;

endpackage
`default_nettype wire

FILE: hdl/trg_grade_unit.sv
// iterative grade calculator: shared constant multiplier and adder under a sequencer
// depends on trg_pkg and text_readability_grade_top_macros.svh
`default_nettype none
`include "text_readability_grade_top_macros.svh"
module trg_grade_unit #(
    parameter int CW = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire trg_pkg::trg_ctl_t ctl,
    input  wire logic [CW-1:0]     letters,
    input  wire logic [CW-1:0]     sentences,
    input  wire logic [CW:0]       words,
    output trg_pkg::trg_sts_t      sts,
    output logic [4:0]             band
);
    import trg_pkg::*;

    localparam int AW = CW + 16;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LET  = 6'b000010,
        S_SEN  = 6'b000100,
        S_WRD  = 6'b001000,
        S_DEN  = 6'b010000,
        S_CMP  = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic signed [AW-1:0]  acc_reg, acc_next;
    logic signed [AW-1:0]  thr_reg, thr_next;
    logic signed [AW-1:0]  den2_reg, den2_next;
    logic [4:0]            band_reg, band_next;

    logic [CW:0]           mul_op;
    logic [KW-1:0]         mul_k;
    logic [CW+KW:0]        prod;
    logic signed [AW-1:0]  prod_s;
    logic signed [AW-1:0]  add_base;
    logic                  add_sub;
    logic signed [AW-1:0]  sum;
    logic signed [AW-1:0]  num2;
    logic                  hit;
    logic                  done_now;

    // operand selection for the shared unit
    always_comb
    begin
        unique case (state_reg)
            S_LET:
            begin
                mul_op   = {1'b0, letters};
                mul_k    = K_LET;
                add_base = '0;
                add_sub  = 1'b0;
            end
            S_SEN:
            begin
                mul_op   = {1'b0, sentences};
                mul_k    = K_SEN;
                add_base = acc_reg;
                add_sub  = 1'b1;
            end
            S_WRD:
            begin
                mul_op   = words;
                mul_k    = K_WRD;
                add_base = acc_reg;
                add_sub  = 1'b1;
            end
            S_CMP:
            begin
                mul_op   = words;
                mul_k    = '0;
                add_base = thr_reg;
                add_sub  = 1'b0;
            end
            default:
            begin
                mul_op   = words;
                mul_k    = K_DEN;
                add_base = '0;
                add_sub  = 1'b0;
            end
        endcase
    end

    assign prod   = mul_op * mul_k;
    assign prod_s = $signed({{(AW-CW-KW-1){1'b0}}, prod});
    // in the compare phase the adder steps the threshold by twice the denominator
    assign sum    = add_sub ? (add_base - prod_s)
                  : (state_reg == S_CMP) ? (add_base + den2_reg)
                  : (add_base + prod_s);
    assign num2   = {acc_reg[AW-2:0], 1'b0};
    assign hit    = (num2 >= thr_reg) && (band_reg < BAND_MAX);

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        thr_next   = thr_reg;
        den2_next  = den2_reg;
        band_next  = band_reg;
        done_now   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = S_LET;
                end
            end
            S_LET:
            begin
                acc_next   = sum;
                state_next = S_SEN;
            end
            S_SEN:
            begin
                acc_next   = sum;
                state_next = S_WRD;
            end
            S_WRD:
            begin
                acc_next   = sum;
                state_next = S_DEN;
            end
            S_DEN:
            begin
                // first threshold is half a grade: den, then 3*den, 5*den ...
                thr_next   = sum;
                den2_next  = {sum[AW-2:0], 1'b0};
                band_next  = '0;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (hit)
                begin
                    band_next = band_reg + 5'd1;
                    thr_next  = sum;
                end
                else if (ctl.out_free)
                begin
                    done_now   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        thr_reg  <= thr_next;
        den2_reg <= den2_next;
        band_reg <= band_next;
    end

    assign sts  = '{busy: (state_reg != S_IDLE), done: done_now};
    assign band = band_reg;

    `TRG_ASSERT_NOW(a_done_needs_room, clk, rst_n, sts.done, ctl.out_free)
    `TRG_ASSERT_NOW(a_start_when_idle, clk, rst_n, ctl.start, state_reg == S_IDLE)
    `TRG_ASSERT_NEXT(a_idle_after_done, clk, rst_n, sts.done, state_reg == S_IDLE)
    `TRG_ASSERT_NOW(a_band_in_range, clk, rst_n, state_reg == S_CMP, band_reg <= BAND_MAX)

endmodule
`default_nettype wire

FILE: hdl/text_readability_grade_top.sv
// top level of the readability grade block: byte classifier, counters, result register
// depends on trg_pkg, trg_grade_unit and text_readability_grade_top_macros.svh
`default_nettype none
`include "text_readability_grade_top_macros.svh"
// Coleman-Liau readability grade. Text arrives one byte per request on the
// input channel, with last_char set on the final byte. Ordinary bytes are
// taken one per cycle while the grade unit is idle, and only update the
// saturating letter, space and sentence-mark counters. The final byte is
// counted; the grade unit then finds the index: three multiply-accumulate
// steps build the numerator, one builds the denominator, then one threshold
// compare per grade band (up to 16) on the shared adder. in_ready is low
// for that time. The result sits in an output register, so bytes of the
// next text are taken while it waits; a second final byte holds off its
// completion until the first result has gone. Counts are cleared once the
// result is loaded. Exact halves round away from zero, and bands clamp to
// 0 (before grade 1) and 16 (16+).
module text_readability_grade_top #(
    parameter int COUNT_MAX = 65535
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire trg_pkg::trg_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output trg_pkg::trg_out_t     out_data
);
    import trg_pkg::*;

    localparam int CW = $clog2(COUNT_MAX + 1);
    localparam int EW = (CW > 17) ? CW : 17;
    localparam logic [CW-1:0] CNT_TOP = CW'(COUNT_MAX);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;

    logic [CW-1:0] letter_reg, letter_next;
    logic [CW-1:0] space_reg, space_next;
    logic [CW-1:0] sent_reg, sent_next;
    logic          out_valid_reg, out_valid_next;
    trg_out_t      out_data_reg, out_data_next;

    logic          in_fire;
    logic          is_letter, is_space, is_sent;
    logic [CW:0]   words;
    logic [EW-1:0] letter_ext, words_ext, sent_ext;
    logic [4:0]    band;
    trg_ctl_t      ctl;
    trg_sts_t      sts;

    // byte classes
    assign is_letter = ((in_data.char_code >= CH_UP_A) && (in_data.char_code <= CH_UP_Z))
                    || ((in_data.char_code >= CH_LO_A) && (in_data.char_code <= CH_LO_Z));
    assign is_space  = (in_data.char_code == CH_SPACE);
    assign is_sent   = (in_data.char_code == CH_DOT) || (in_data.char_code == CH_BANG)
                    || (in_data.char_code == CH_QUERY);

    // requests are refused only while the grade unit runs
    assign in_ready = !sts.busy;
    assign in_fire  = in_valid && in_ready;

    assign ctl.start    = in_fire && in_data.last_char;
    assign ctl.out_free = !out_valid_reg || out_ready;

    assign words = {1'b0, space_reg} + {{CW{1'b0}}, 1'b1};

    // widen before masking to the fixed output field widths
    assign letter_ext = EW'(letter_reg);
    assign words_ext  = EW'(words);
    assign sent_ext   = EW'(sent_reg);

    always_comb
    begin
        letter_next    = letter_reg;
        space_next     = space_reg;
        sent_next      = sent_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // saturating counters
        if (in_fire)
        begin
            if (is_letter && (letter_reg != CNT_TOP))
            begin
                letter_next = letter_reg + {{(CW-1){1'b0}}, 1'b1};
            end
            if (is_space && (space_reg != CNT_TOP))
            begin
                space_next = space_reg + {{(CW-1){1'b0}}, 1'b1};
            end
            if (is_sent && (sent_reg != CNT_TOP))
            begin
                sent_next = sent_reg + {{(CW-1){1'b0}}, 1'b1};
            end
        end

        // load the result and start the next text from clear counts
        if (sts.done)
        begin
            out_valid_next               = 1'b1;
            out_data_next.grade_band     = band;
            out_data_next.letter_total   = letter_ext[15:0];
            out_data_next.word_total     = words_ext[16:0];
            out_data_next.sentence_total = sent_ext[15:0];
            letter_next                  = '0;
            space_next                   = '0;
            sent_next                    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            letter_reg    <= '0;
            space_reg     <= '0;
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            letter_reg    <= letter_next;
            space_reg     <= space_next;
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    trg_grade_unit #(
        .CW (CW)
    ) u_grade (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .letters   (letter_reg),
        .sentences (sent_reg),
        .words     (words),
        .sts       (sts),
        .band      (band)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `TRG_ASSERT_NOW(a_no_request_while_busy, clk, rst_n, sts.busy, !in_ready)
    `TRG_ASSERT_NEXT(a_counts_cleared, clk, rst_n, sts.done, (letter_reg == '0) && (sent_reg == '0))
    `TRG_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// testbench for text_readability_grade_top: queued byte stream, model of the counters and grade
// depends on trg_pkg and the block's RTL only
module tb;

    import trg_pkg::*;

    // counter ceiling, kept equal to the block's parameter
    localparam int unsigned CNT_LIMIT = 65535;
    // receiver hold-off that fills the output register and stalls the input
    localparam int unsigned STALL_STRETCH = 400;
    // nothing accepted for this many cycles means the block is stuck
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    // drain time after the last grade: well above the longest grade latency
    localparam int unsigned DRAIN_CYCLES = 64;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_UPPER = 8'h41;
    localparam logic [7:0] CH_LOWER = 8'h61;

    // one queued byte and the idle cycles the sender waits before offering it
    typedef struct {
        trg_in_t     req;
        int unsigned gap;
    } byte_slot_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    trg_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    trg_out_t out_data;

    byte_slot_t  byte_backlog[$];
    byte_slot_t  next_slot;
    trg_out_t    grade_expect_q[$];

    // running counts of the text being taken, as the block should hold them
    int unsigned tally_letters = 0;
    int unsigned tally_spaces = 0;
    int unsigned tally_marks = 0;

    int unsigned sender_idle = 0;
    int unsigned ready_wait = 0;
    int unsigned quiet_cycles = 0;
    int unsigned bytes_taken = 0;
    int unsigned texts_taken = 0;
    int unsigned grades_checked = 0;
    int unsigned error_count = 0;
    logic [16:0] bands_seen = '0;

    text_readability_grade_top #(
        .COUNT_MAX(CNT_LIMIT)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // coleman-liau index in exact integers, rounded half away from zero, clamped to a band
    function automatic logic [4:0] grade_band_of(longint letters, longint words,
                                                 longint sentences);
        longint num;
        longint den;
        longint q;
        num = longint'(K_LET) * letters - longint'(K_SEN) * sentences
              - longint'(K_WRD) * words;
        den = longint'(K_DEN) * words;
        if (num >= 0)
            q = (2 * num + den) / (2 * den);
        else
            q = -((-2 * num + den) / (2 * den));
        if (q < 1)
            return 5'd0;
        if (q > longint'(BAND_MAX))
            return BAND_MAX;
        return q[4:0];
    endfunction

    // update the counts for one taken byte; on the final byte queue the grade and clear
    function automatic void count_and_grade(trg_in_t req);
        trg_out_t    grade;
        int unsigned words;
        if ((req.char_code >= CH_UPPER && req.char_code <= CH_UPPER + 8'd25) ||
            (req.char_code >= CH_LOWER && req.char_code <= CH_LOWER + 8'd25))
        begin
            if (tally_letters < CNT_LIMIT)
                tally_letters++;
        end
        else if (req.char_code == CH_SPACE)
        begin
            if (tally_spaces < CNT_LIMIT)
                tally_spaces++;
        end
        else if (req.char_code == CH_DOT || req.char_code == CH_BANG ||
                 req.char_code == CH_QUERY)
        begin
            if (tally_marks < CNT_LIMIT)
                tally_marks++;
        end
        if (req.last_char)
        begin
            words = tally_spaces + 1;
            grade.grade_band     = grade_band_of(tally_letters, words, tally_marks);
            grade.letter_total   = tally_letters[15:0];
            grade.word_total     = words[16:0];
            grade.sentence_total = tally_marks[15:0];
            grade_expect_q.push_back(grade);
            tally_letters = 0;
            tally_spaces = 0;
            tally_marks = 0;
        end
    endfunction

    function automatic void compare_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endfunction

    function automatic void queue_byte(logic [7:0] code, logic last, int unsigned gap);
        byte_slot_t slot;
        slot.req.char_code = code;
        slot.req.last_char = last;
        slot.gap = gap;
        byte_backlog.push_back(slot);
    endfunction

    // driver: offers queued bytes, holding each until taken, with its drawn gap in front
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            sender_idle = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                count_and_grade(in_data);
                bytes_taken++;
                if (in_data.last_char)
                    texts_taken++;
            end
            // a request not yet taken stays on the bus unchanged
            if (!(in_valid && !in_ready))
            begin
                if (byte_backlog.size() == 0)
                    in_valid <= 1'b0;
                else if (sender_idle < byte_backlog[0].gap)
                begin
                    sender_idle++;
                    in_valid <= 1'b0;
                end
                else
                begin
                    next_slot = byte_backlog.pop_front();
                    in_data <= next_slot.req;
                    in_valid <= 1'b1;
                    sender_idle = 0;
                end
            end
        end
    end

    // monitor: checks each grade against the oldest expectation, then draws its own stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_wait = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (grade_expect_q.size() == 0)
                begin
                    $error("unexpected grade: no final byte pending, band %0d",
                           out_data.grade_band);
                    error_count++;
                end
                else
                begin
                    trg_out_t want;
                    want = grade_expect_q.pop_front();
                    compare_field("grade_band", want.grade_band, out_data.grade_band);
                    compare_field("letter_total", want.letter_total, out_data.letter_total);
                    compare_field("word_total", want.word_total, out_data.word_total);
                    compare_field("sentence_total", want.sentence_total,
                                  out_data.sentence_total);
                    if (want.grade_band <= BAND_MAX)
                        bands_seen[want.grade_band] = 1'b1;
                end
                grades_checked++;
                // two long hold-offs so a second final byte backs up behind the result
                if (grades_checked == 4 || grades_checked == 40)
                    ready_wait = STALL_STRETCH;
                else if ((grades_checked / 16) % 3 == 1)
                    ready_wait = 0;
                else
                    ready_wait = $urandom_range(0, 17);
                out_ready <= (ready_wait == 0);
            end
            else if (ready_wait > 0)
            begin
                ready_wait--;
                out_ready <= (ready_wait == 0);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog on cycles where neither channel moves a request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no request moved for %0d cycles", quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        string       half_text;
        int unsigned counted;
        int unsigned texts;
        int unsigned len;
        int unsigned pick;
        int unsigned p_letter;
        int unsigned p_space;
        int unsigned p_mark;
        bit          calm;
        bit          noise;
        logic [7:0]  code;

        counted = 0;
        texts = 0;

        // single-byte texts: ignored extremes, a letter, a space, a mark
        queue_byte(8'h00, 1'b1, $urandom_range(0, 17));
        queue_byte(8'hFF, 1'b1, $urandom_range(0, 17));
        queue_byte(CH_UPPER, 1'b1, $urandom_range(0, 17));
        queue_byte(CH_SPACE, 1'b1, $urandom_range(0, 17));
        queue_byte(CH_QUERY, 1'b1, $urandom_range(0, 17));

        // 15 letters, 2 words, 1 mark: index is exactly 13.5 and must round to 14;
        // also the letter range edges and the bytes just outside them
        half_text = "Aa@zz Z[bcdefghij`k{!";
        for (int i = 0; i < half_text.len(); i++)
            queue_byte(half_text[i], i == half_text.len() - 1, $urandom_range(0, 17));

        // random texts with their own mix of letters, spaces, marks and stray bytes
        while (counted < 1050 || texts < 60)
        begin
            if ($urandom_range(0, 3) == 0)
                len = $urandom_range(1, 4);
            else
                len = $urandom_range(5, 40);
            p_letter = $urandom_range(50, 90);
            p_space = $urandom_range(5, 25);
            p_mark = $urandom_range(0, 8);
            calm = ($urandom_range(0, 3) == 0);
            for (int unsigned k = 0; k < len; k++)
            begin
                pick = $urandom_range(0, 99);
                noise = 1'b0;
                if (pick < p_letter)
                    code = ($urandom_range(0, 1) ? CH_UPPER : CH_LOWER)
                           + 8'($urandom_range(0, 25));
                else if (pick < p_letter + p_space)
                    code = CH_SPACE;
                else if (pick < p_letter + p_space + p_mark)
                begin
                    case ($urandom_range(0, 2))
                        0: code = CH_DOT;
                        1: code = CH_BANG;
                        default: code = CH_QUERY;
                    endcase
                end
                else
                begin
                    code = 8'($urandom_range(0, 255));
                    noise = 1'b1;
                end
                queue_byte(code, k == len - 1, calm ? 0 : $urandom_range(0, 17));
                if (!noise || k == len - 1)
                    counted++;
            end
            texts++;
        end

        // wait for the stream to be taken and every grade to come back
        @(posedge clk);
        while (byte_backlog.size() != 0 || in_valid)
            @(posedge clk);
        while (grade_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d bytes in %0d texts taken, %0d grades checked",
                 bytes_taken, texts_taken, grades_checked);
        $display("%0d of 17 grade bands reached, with two long receiver stalls",
                 $countones(bands_seen));
        if (error_count == 0 && grade_expect_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // reset held low at the start, released once at a rising edge
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

endmodule
